@@ hw/rtl/ctd_pkg.sv @@
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types and constants for the 12+1 crank trigger decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int TsW      = 32;
  localparam int CntW     = 4;
  localparam int AngW     = 10;
  localparam int OffW     = 10;
  localparam int AccW     = 12;
  localparam int OutDataW = 144;

  localparam logic [CntW-1:0] CountMax   = 4'd15;
  localparam logic [CntW-1:0] WrapCount  = 4'd13;
  localparam logic [CntW-1:0] ToothOne   = 4'd1;
  localparam logic [CntW-1:0] LastReal   = 4'd11;
  localparam int              ToothDeg   = 360 / 12;
  localparam int              CycleDeg   = 720;
  localparam int              HalfDeg    = 360;

  typedef enum logic {
    REQ_TOOTH     = 1'b0,
    REQ_SYNC_LOST = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [TsW-1:0]  current_gap;
    logic [TsW-1:0]  previous_gap;
    logic [CntW-1:0] tooth_counter;
    logic            sync_flag;
    logic [TsW-1:0]  last_tooth_time;
    logic [TsW-1:0]  second_last_tooth_time;
    logic [TsW-1:0]  tooth_one_stamp;
    logic [TsW-1:0]  prior_tooth_one_stamp;
    logic [TsW-1:0]  revolutions;
  } ctd_state_t;

  typedef struct packed {
    logic [TsW-1:0]  tooth_one_time_us;
    logic [TsW-1:0]  last_tooth_time_us;
    logic [TsW-1:0]  revolution_count;
    logic [TsW-1:0]  tooth_gap_us;
    logic [AngW-1:0] crank_angle_deg;
    logic [CntW-1:0] tooth_number;
    logic            has_sync;
  } ctd_result_t;

endpackage

@@ hw/rtl/ctd_step.sv @@
// ----------------------------------------------------------------------------
// ctd_step
// Next-state and result logic for one tooth or sync-lost word of the 12+1 decoder.
// ----------------------------------------------------------------------------
module ctd_step
  import ctd_pkg::*;
(
  input  ctd_state_t             state,
  input  logic signed [OffW-1:0] angle_offset,
  input  req_type_t              req_type,
  input  logic [TsW-1:0]         timestamp_us,
  output ctd_state_t             state_next,
  output ctd_result_t            result
);

  logic [CntW-1:0]        cnt_inc;
  logic [TsW-1:0]         gap;
  logic [CntW-1:0]        ang_idx;
  logic [AccW-1:0]        base_deg;
  logic signed [AccW-1:0] raw_deg;
  logic signed [AccW-1:0] plus_half;
  logic signed [AccW-1:0] wrapped;

  always_comb begin
    state_next = state;
    gap        = timestamp_us - state.last_tooth_time;
    cnt_inc    = (state.tooth_counter < CountMax) ? state.tooth_counter + 4'd1
                                                  : state.tooth_counter;
    unique case (req_type)
      REQ_SYNC_LOST: begin
        state_next.sync_flag = 1'b0;
      end
      REQ_TOOTH: begin
        state_next.previous_gap  = state.current_gap;
        state_next.current_gap   = gap;
        state_next.tooth_counter = cnt_inc;
        priority if (state.sync_flag && cnt_inc == WrapCount) begin
          state_next.tooth_counter = '0;
        end else if (state.sync_flag && cnt_inc == ToothOne) begin
          state_next.prior_tooth_one_stamp  = state.tooth_one_stamp;
          state_next.tooth_one_stamp        = timestamp_us;
          state_next.revolutions            = state.revolutions + 32'd1;
          state_next.second_last_tooth_time = state.last_tooth_time;
          state_next.last_tooth_time        = timestamp_us;
        end else if (gap < (state.current_gap >> 1)) begin
          state_next.tooth_counter = '0;
          state_next.sync_flag     = 1'b1;
        end else begin
          state_next.second_last_tooth_time = state.last_tooth_time;
          state_next.last_tooth_time        = timestamp_us;
        end
      end
      default: state_next = state;
    endcase
  end

  // tooth-resolution angle, wrapped into one engine cycle
  always_comb begin
    ang_idx   = (state_next.tooth_counter == '0) ? LastReal
                                                 : state_next.tooth_counter - 4'd1;
    base_deg  = AccW'(ang_idx) * AccW'(ToothDeg);
    raw_deg   = $signed(base_deg) + AccW'(angle_offset);
    plus_half = raw_deg + AccW'(HalfDeg);
    priority if (raw_deg >= AccW'(CycleDeg)) begin
      wrapped = raw_deg - AccW'(CycleDeg);
    end else if (raw_deg >= 0) begin
      wrapped = raw_deg;
    end else if (plus_half >= 0) begin
      wrapped = plus_half;
    end else begin
      wrapped = plus_half + AccW'(HalfDeg);
    end
  end

  assign result.has_sync           = state_next.sync_flag;
  assign result.tooth_number       = state_next.tooth_counter;
  assign result.crank_angle_deg    = wrapped[AngW-1:0];
  assign result.tooth_gap_us       = state_next.current_gap;
  assign result.revolution_count   = state_next.revolutions;
  assign result.last_tooth_time_us = state_next.last_tooth_time;
  assign result.tooth_one_time_us  = state_next.tooth_one_stamp;

endmodule

@@ hw/rtl/crank_trigger_12_plus_1_decoder_core.sv @@
// ----------------------------------------------------------------------------
// crank_trigger_12_plus_1_decoder_core
// Tooth decoder for a 12+1 crank wheel with a tooth-resolution angle output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = request kind (0 tooth edge, 1 sync lost), tdata =
//   timestamp in microseconds. Each accepted word yields exactly one master
//   word with sync flag, tooth number, crank angle, gap, revolution count,
//   last tooth time and tooth-one time.
//   cfg_valid/cfg_ready write the signed trigger angle offset; write it only
//   while the block holds no word.
//   The word passes two register stages: the input register takes the word at
//   the accepting edge, and the state update and angle wrap then land in the
//   output register with m_tvalid high. Throughput is one word per cycle while
//   the receiver does not stall, set by the combinational state update loop.
//   Reset clears the decoder state and the offset and empties both word
//   registers.
//   When the receiver stalls the output word holds; one more word waits in
//   the input register, after which s_tready drops.
// ----------------------------------------------------------------------------
module crank_trigger_12_plus_1_decoder_core
  import ctd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [OffW-1:0]     cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [TsW-1:0]      s_tdata,   // [31:0] timestamp_us
  input  logic                s_tuser,   // [0] req_type
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // has_sync, tooth_number, crank_angle_deg,
                                         // tooth_gap_us, revolution_count,
                                         // last_tooth_time_us, tooth_one_time_us, pad
);

  logic                   in_valid;
  req_type_t              in_req;
  logic [TsW-1:0]         in_ts;
  logic signed [OffW-1:0] angle_offset;
  ctd_state_t             state;
  ctd_state_t             state_next;
  ctd_result_t            result;
  ctd_result_t            out_word;
  logic                   advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || !m_tvalid || m_tready;

  ctd_step u_step (
    .state        (state),
    .angle_offset (angle_offset),
    .req_type     (in_req),
    .timestamp_us (in_ts),
    .state_next   (state_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      angle_offset <= '0;
      state        <= '0;
    end else begin
      if (cfg_valid) begin
        angle_offset <= $signed(cfg_data);
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req <= req_type_t'(s_tuser);
      in_ts  <= s_tdata;
    end
    if (advance) begin
      out_word <= result;
    end
  end

  assign m_tdata = {1'b0, out_word};

endmodule

@@ hw/rtl/ctd_checker.sv @@
// ----------------------------------------------------------------------------
// ctd_checker
// Port-level checks for the 12+1 crank trigger decoder.
// ----------------------------------------------------------------------------
module ctd_checker
  import ctd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word present after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[14:5] < 10'd720)
    else $error("crank angle out of range");

  a_sync_tooth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[4:1] <= 4'd12)
    else $error("tooth count past wrap while synced");

endmodule

bind crank_trigger_12_plus_1_decoder_core ctd_checker u_ctd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/sv/tb_crank_trigger_12_plus_1_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_crank_trigger_12_plus_1_decoder_core
// Self-checking bench for the 12+1 crank trigger decoder. A short table of
// tooth and sync-lost words walks the timestamp extremes, the extra-tooth
// sync, tooth one, the unsynced count saturation and resync. Random wheel
// revolutions with noise, dropped extra teeth and lost sync follow over several
// angle offsets, idling at random on both streams but in the last. Each result
// word is checked per field against typed rows or an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_crank_trigger_12_plus_1_decoder_core;
  import ctd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_type_t      kind;
    logic [TsW-1:0] stamp;
    bit             typed;
    ctd_result_t    want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [OffW-1:0]     cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TsW-1:0]      s_tdata = '0;   // [31:0] timestamp_us
  logic                s_tuser = 1'b0; // [0] req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;        // has_sync, tooth_number, crank_angle_deg,
                                       // tooth_gap_us, revolution_count,
                                       // last_tooth_time_us, tooth_one_time_us, pad

  // decoder model state
  logic [TsW-1:0]  gap_now;
  logic [TsW-1:0]  gap_prev;
  logic [CntW-1:0] tooth_cnt;
  logic            synced;
  logic [TsW-1:0]  last_stamp;
  logic [TsW-1:0]  t1_stamp;
  logic [TsW-1:0]  revs;
  int              offset_deg;

  ctd_result_t pending_results[$];
  int          mismatches = 0;
  int          sent_words = 0;
  bit          steady = 1'b0;
  int          stall_left = 0;

  crank_trigger_12_plus_1_decoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic ctd_result_t result_of(input logic sync, input logic [CntW-1:0] cnt,
                                            input logic [AngW-1:0] ang,
                                            input logic [TsW-1:0] gap,
                                            input logic [TsW-1:0] rev,
                                            input logic [TsW-1:0] last,
                                            input logic [TsW-1:0] one);
    ctd_result_t r;
    r.has_sync           = sync;
    r.tooth_number       = cnt;
    r.crank_angle_deg    = ang;
    r.tooth_gap_us       = gap;
    r.revolution_count   = rev;
    r.last_tooth_time_us = last;
    r.tooth_one_time_us  = one;
    return r;
  endfunction

  function automatic ctd_result_t decode_word(input req_type_t kind,
                                              input logic [TsW-1:0] stamp);
    int deg;
    if (kind == REQ_SYNC_LOST) begin
      synced = 1'b0;
    end else begin
      gap_prev = gap_now;
      gap_now  = stamp - last_stamp;
      if (tooth_cnt != CountMax) tooth_cnt = tooth_cnt + 1'b1;
      if (synced && tooth_cnt == WrapCount) begin
        tooth_cnt = '0;
      end else if (synced && tooth_cnt == ToothOne) begin
        t1_stamp   = stamp;
        revs       = revs + 1;
        last_stamp = stamp;
      end else if (gap_now < (gap_prev >> 1)) begin
        tooth_cnt = '0;
        synced    = 1'b1;
      end else begin
        last_stamp = stamp;
      end
    end
    if (tooth_cnt == '0) deg = int'(LastReal) * ToothDeg;
    else deg = (int'(tooth_cnt) - 1) * ToothDeg;
    deg = deg + offset_deg;
    if (deg >= CycleDeg) deg = deg - CycleDeg;
    while (deg < 0) deg = deg + HalfDeg;
    return result_of(synced, tooth_cnt, deg[AngW-1:0], gap_now, revs, last_stamp, t1_stamp);
  endfunction

  task automatic send_word(input req_type_t kind, input logic [TsW-1:0] stamp,
                           input bit typed, input ctd_result_t want);
    ctd_result_t r;
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= stamp;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    r = decode_word(kind, stamp);
    pending_results.push_back(typed ? want : r);
    sent_words++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(input int off);
    cfg_valid <= 1'b1;
    cfg_data  <= off[OffW-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid  <= 1'b0;
    offset_deg = off;
  endtask

  // well-formed revolutions with noise, lost sync and dropped extra teeth
  task automatic run_wheel(input int upto);
    logic [TsW-1:0] stamp;
    logic [TsW-1:0] pitch;
    int             pick;
    stamp = $urandom();
    while (sent_words < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) pitch = $urandom_range(50, 20000);
      else if (pick < 95) pitch = $urandom_range(20000, 5000000);
      else pitch = $urandom_range(1 << 24, 1 << 30);
      for (int t = 0; t < 12 && sent_words < upto; t++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_word(REQ_SYNC_LOST, $urandom(), 1'b0, '0);
        end else if (pick < 9) begin
          send_word(REQ_TOOTH, $urandom(), 1'b0, '0);
        end
        stamp = stamp + pitch + $urandom_range(0, pitch >> 4);
        send_word(REQ_TOOTH, stamp, 1'b0, '0);
      end
      if ($urandom_range(0, 19) != 0)
        send_word(REQ_TOOTH, stamp + $urandom_range(1, pitch >> 2), 1'b0, '0);
    end
  endtask

  task automatic note_field(input string what, input logic [TsW-1:0] want,
                            input logic [TsW-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, actual %h", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ctd_result_t got;
    ctd_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = ctd_result_t'(m_tdata[$bits(ctd_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        note_field("has_sync", want.has_sync, got.has_sync);
        note_field("tooth_number", want.tooth_number, got.tooth_number);
        note_field("crank_angle_deg", want.crank_angle_deg, got.crank_angle_deg);
        note_field("tooth_gap_us", want.tooth_gap_us, got.tooth_gap_us);
        note_field("revolution_count", want.revolution_count, got.revolution_count);
        note_field("last_tooth_time_us", want.last_tooth_time_us, got.last_tooth_time_us);
        note_field("tooth_one_time_us", want.tooth_one_time_us, got.tooth_one_time_us);
      end
    end
  end

  initial begin
    dir_row_t dir_rows[23];
    int       offsets[6];
    gap_now    = '0;
    gap_prev   = '0;
    tooth_cnt  = '0;
    synced     = 1'b0;
    last_stamp = '0;
    t1_stamp   = '0;
    revs       = '0;
    offset_deg = 0;
    dir_rows = '{
      '{REQ_TOOTH, 32'h0000_0000, 1'b1, result_of(1'b0, 4'd1, 10'd0, 32'd0, 32'd0, 32'd0, 32'd0)},
      '{REQ_TOOTH, 32'd1000, 1'b1,
        result_of(1'b0, 4'd2, 10'd30, 32'd1000, 32'd0, 32'd1000, 32'd0)},
      '{REQ_TOOTH,     32'hFFFF_FFFF, 1'b0, '0},
      '{REQ_TOOTH,     32'h0000_0100, 1'b0, '0},
      '{REQ_TOOTH,     32'h1000_0000, 1'b0, '0},
      '{REQ_SYNC_LOST, 32'hFFFF_FFFF, 1'b0, '0},
      '{REQ_TOOTH,     32'h2000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h3000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h4000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h5000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h6000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h7000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h8000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h9000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'hA000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'hB000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'hC000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'hD000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'hE000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'hF000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h0000_0000, 1'b0, '0},
      '{REQ_TOOTH,     32'h0000_0010, 1'b0, '0},
      '{REQ_SYNC_LOST, 32'h0000_0000, 1'b0, '0}
    };
    offsets = '{-360, 359, 0, 0, 0, 0};
    offsets[3] = int'($urandom_range(0, 719)) - 360;
    offsets[4] = int'($urandom_range(0, 719)) - 360;
    offsets[5] = int'($urandom_range(0, 719)) - 360;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_offset(offsets[p]);
      if (p == 5) steady = 1'b1;
      if (p == 2) begin
        run_wheel(sent_words + 128);
        drain_results();
      end
      run_wheel(23 + (p + 1) * 255);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("crank_trigger_12_plus_1_decoder_core test passed");
    end else begin
      $display("crank_trigger_12_plus_1_decoder_core test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("crank_trigger_12_plus_1_decoder_core test failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ctd_pkg.sv
hw/rtl/ctd_step.sv
hw/rtl/crank_trigger_12_plus_1_decoder_core.sv
hw/rtl/ctd_checker.sv
tb/sv/tb_crank_trigger_12_plus_1_decoder_core.sv
